FILE: hdl/assert_macros.svh
// assertion helpers used by the rtl bus engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hdl/i2cdw_pkg.sv
package i2cdw_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_BIT_SETUP = 4'd3,
        PH_BIT_HIGH  = 4'd4,
        PH_BIT_LOW   = 4'd5,
        PH_ACK_SETUP = 4'd6,
        PH_ACK_CLOCK = 4'd7,
        PH_ACK_POLL  = 4'd8,
        PH_STOP_A    = 4'd9,
        PH_STOP_B    = 4'd10
    } t_phase;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_COMMAND = 2'd1;
    localparam logic [1:0] CMD_DATA = 2'd2;

    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_TICKS_PER_US = 2'd2;

    localparam logic [7:0] RST_SLAVE_ADDRESS = 8'h78;
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;
    localparam logic [7:0] RST_TICKS_PER_US = 8'd1;

    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    localparam logic [2:0] UNITS_EDGE = 3'd4;
    localparam logic [2:0] UNITS_BIT = 3'd2;
    localparam logic [2:0] UNITS_ACK = 3'd1;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    // classified request as it sits between front and engine
    typedef struct packed {
        logic       req;
        logic       is_data;
        logic [7:0] payload;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic busy_res;
        logic accepted;
        logic done_res;
        logic ack_error;
    } t_result;

    function automatic logic [9:0] f_delay_load(input logic [2:0] units,
                                                input logic [7:0] tpu);
        logic [7:0]  u;
        logic [10:0] prod;
        u = (tpu == 8'd0) ? 8'd1 : tpu;
        prod = {3'b000, u} * {8'd0, units};
        return prod[9:0];
    endfunction

endpackage

FILE: hdl/i2cdw_front.sv
module i2cdw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_payload,
    input  logic               i_sda_in,
    input  logic               i_pop,
    output logic               o_valid,
    output i2cdw_pkg::t_item   o_item
);

    i2cdw_pkg::t_item r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;
    i2cdw_pkg::t_item w_item;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // tick and the unused code both become plain ticks
    always_comb begin
        w_item.req     = (i_cmd == i2cdw_pkg::CMD_COMMAND) || (i_cmd == i2cdw_pkg::CMD_DATA);
        w_item.is_data = (i_cmd == i2cdw_pkg::CMD_DATA);
        w_item.payload = i_payload;
        w_item.sda_in  = i_sda_in;
    end

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/i2cdw_result_q.sv
module i2cdw_result_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cdw_pkg::t_result i_res,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output i2cdw_pkg::t_result o_res
);

    i2cdw_pkg::t_result r_slot [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic [1:0]         n_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/i2cdw_engine.sv
`include "assert_macros.svh"

module i2cdw_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cdw_pkg::t_cfg_wr i_cfg,
    input  logic               i_item_valid,
    input  i2cdw_pkg::t_item   i_item,
    output logic               o_item_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output i2cdw_pkg::t_result o_res
);

    logic [7:0] r_slave_address;
    logic [7:0] r_ack_timeout;
    logic [7:0] r_ticks_per_us;

    i2cdw_pkg::t_phase r_phase;
    i2cdw_pkg::t_phase n_phase;
    logic [1:0] r_byte_index;
    logic [1:0] n_byte_index;
    logic [2:0] r_bit_count;
    logic [2:0] n_bit_count;
    logic [9:0] r_delay;
    logic [9:0] n_delay;
    logic [7:0] r_poll;
    logic [7:0] n_poll;
    logic [7:0] r_shift;
    logic [7:0] n_shift;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       r_is_data;
    logic       n_is_data;
    logic       r_scl;
    logic       n_scl;
    logic       r_sda;
    logic       n_sda;
    logic       r_err;
    logic       n_err;

    logic       w_step;
    logic       w_acc;
    logic       w_done;
    logic [8:0] w_poll_inc;
    logic [7:0] w_byte_val;
    logic [1:0] w_next_byte;

    assign w_step     = i_item_valid && !i_res_full;
    assign o_item_pop = w_step;
    assign o_res_push = w_step;

    assign w_poll_inc  = {1'b0, r_poll} + 9'd1;
    assign w_next_byte = r_byte_index + 2'd1;
    assign w_byte_val  = (w_next_byte == 2'd1)
                       ? (r_is_data ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_COMMAND)
                       : r_held;

    // next state: one bus tick per request
    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_bit_count  = r_bit_count;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_shift      = r_shift;
        n_held       = r_held;
        n_is_data    = r_is_data;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_err        = r_err;
        w_acc        = 1'b0;
        w_done       = 1'b0;

        if (r_phase == i2cdw_pkg::PH_IDLE) begin
            if (i_item.req) begin
                w_acc        = 1'b1;
                n_held       = i_item.payload;
                n_is_data    = i_item.is_data;
                n_err        = 1'b0;
                n_byte_index = 2'd0;
                n_bit_count  = 3'd0;
                n_poll       = 8'd0;
                n_scl        = 1'b1;
                n_sda        = 1'b1;
                n_phase      = i2cdw_pkg::PH_START_A;
                n_delay      = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_EDGE, r_ticks_per_us);
            end
        end else if (r_phase == i2cdw_pkg::PH_ACK_POLL) begin
            if (!i_item.sda_in) begin
                n_scl = 1'b0;
                if (r_byte_index >= 2'd2) begin
                    n_sda   = 1'b0;
                    n_phase = i2cdw_pkg::PH_STOP_A;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_EDGE, r_ticks_per_us);
                end else begin
                    n_byte_index = w_next_byte;
                    n_bit_count  = 3'd0;
                    n_sda        = w_byte_val[7];
                    n_shift      = {w_byte_val[6:0], 1'b0};
                    n_phase      = i2cdw_pkg::PH_BIT_SETUP;
                    n_delay      = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_BIT, r_ticks_per_us);
                end
            end else if (w_poll_inc > {1'b0, r_ack_timeout}) begin
                // acknowledge missing: abort with stop
                n_err   = 1'b1;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_phase = i2cdw_pkg::PH_STOP_A;
                n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_EDGE, r_ticks_per_us);
            end else begin
                n_poll = w_poll_inc[7:0];
            end
        end else if (r_delay > 10'd1) begin
            n_delay = r_delay - 10'd1;
        end else begin
            n_delay = 10'd0;
            case (r_phase)
                i2cdw_pkg::PH_START_A: begin
                    n_sda   = 1'b0;
                    n_phase = i2cdw_pkg::PH_START_B;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_EDGE, r_ticks_per_us);
                end
                i2cdw_pkg::PH_START_B: begin
                    n_byte_index = 2'd0;
                    n_bit_count  = 3'd0;
                    n_scl        = 1'b0;
                    n_sda        = r_slave_address[7];
                    n_shift      = {r_slave_address[6:0], 1'b0};
                    n_phase      = i2cdw_pkg::PH_BIT_SETUP;
                    n_delay      = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_BIT, r_ticks_per_us);
                end
                i2cdw_pkg::PH_BIT_SETUP: begin
                    n_scl   = 1'b1;
                    n_phase = i2cdw_pkg::PH_BIT_HIGH;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_BIT, r_ticks_per_us);
                end
                i2cdw_pkg::PH_BIT_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = i2cdw_pkg::PH_BIT_LOW;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_BIT, r_ticks_per_us);
                end
                i2cdw_pkg::PH_BIT_LOW: begin
                    if (r_bit_count == 3'd7) begin
                        n_bit_count = 3'd0;
                        n_sda       = 1'b1;
                        n_phase     = i2cdw_pkg::PH_ACK_SETUP;
                        n_delay     = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_ACK,
                                                              r_ticks_per_us);
                    end else begin
                        n_bit_count = r_bit_count + 3'd1;
                        n_scl       = 1'b0;
                        n_sda       = r_shift[7];
                        n_shift     = {r_shift[6:0], 1'b0};
                        n_phase     = i2cdw_pkg::PH_BIT_SETUP;
                        n_delay     = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_BIT,
                                                              r_ticks_per_us);
                    end
                end
                i2cdw_pkg::PH_ACK_SETUP: begin
                    n_scl   = 1'b1;
                    n_phase = i2cdw_pkg::PH_ACK_CLOCK;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_ACK, r_ticks_per_us);
                end
                i2cdw_pkg::PH_ACK_CLOCK: begin
                    n_poll  = 8'd0;
                    n_phase = i2cdw_pkg::PH_ACK_POLL;
                end
                i2cdw_pkg::PH_STOP_A: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = i2cdw_pkg::PH_STOP_B;
                    n_delay = i2cdw_pkg::f_delay_load(i2cdw_pkg::UNITS_EDGE, r_ticks_per_us);
                end
                i2cdw_pkg::PH_STOP_B: begin
                    n_phase = i2cdw_pkg::PH_IDLE;
                    w_done  = 1'b1;
                end
                default: begin
                    n_phase = i2cdw_pkg::PH_IDLE;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
            endcase
        end
    end

    // result reports the line levels after this tick
    always_comb begin
        o_res.scl_out   = n_scl;
        o_res.sda_out   = n_sda;
        o_res.busy_res  = (n_phase != i2cdw_pkg::PH_IDLE);
        o_res.accepted  = w_acc;
        o_res.done_res  = w_done;
        o_res.ack_error = w_done && r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= i2cdw_pkg::RST_SLAVE_ADDRESS;
            r_ack_timeout   <= i2cdw_pkg::RST_ACK_TIMEOUT;
            r_ticks_per_us  <= i2cdw_pkg::RST_TICKS_PER_US;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                i2cdw_pkg::CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg.data;
                i2cdw_pkg::CFG_ACK_TIMEOUT:   r_ack_timeout   <= i_cfg.data;
                i2cdw_pkg::CFG_TICKS_PER_US:  r_ticks_per_us  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cdw_pkg::PH_IDLE;
            r_byte_index <= 2'd0;
            r_bit_count  <= 3'd0;
            r_delay      <= 10'd0;
            r_poll       <= 8'd0;
            r_shift      <= 8'd0;
            r_held       <= 8'd0;
            r_is_data    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_err        <= 1'b0;
        end else if (w_step) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_bit_count  <= n_bit_count;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_shift      <= n_shift;
            r_held       <= n_held;
            r_is_data    <= n_is_data;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_err        <= n_err;
        end
    end

    `ASSERT_PROP(a_done_from_stop, i_clk, i_rst_n, (w_step && w_done) |-> (r_phase == i2cdw_pkg::PH_STOP_B))
    `ASSERT_PROP(a_accept_starts, i_clk, i_rst_n, (w_step && w_acc) |=> (r_phase == i2cdw_pkg::PH_START_A))
    `ASSERT_NEVER(a_idle_lines_free, i_clk, i_rst_n, (r_phase == i2cdw_pkg::PH_IDLE) && !(r_scl && r_sda))

endmodule

FILE: hdl/i2c_display_write_master.sv
// Write-only I2C master for a display controller. Every request is one bus tick
// (cmd 0 or 3) or a command/data byte to send (cmd 1/2); each request yields exactly
// one result with the SCL/SDA drive levels after that tick plus busy, accepted, done
// and ack_error flags. A byte request, taken while idle, runs START, address byte,
// control byte (0x00 or 0x40), payload and STOP over the following ticks, with a
// missing acknowledge aborting into STOP. While the result queue is not full, the
// block takes one request per clock: a two-entry input queue feeds a bus engine that
// executes one tick per cycle into a two-entry result queue, and the engine step sets
// the sustained rate of one item per clock. Configuration writes are always ready and
// must only be made while idle.
module i2c_display_write_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_payload,
    input  logic       i_sda_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_accepted,
    output logic       o_done_res,
    output logic       o_ack_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    i2cdw_pkg::t_cfg_wr w_cfg;
    i2cdw_pkg::t_item   w_item;
    i2cdw_pkg::t_result w_res_in;
    i2cdw_pkg::t_result w_res_out;
    logic               w_item_valid;
    logic               w_item_pop;
    logic               w_res_full;
    logic               w_res_push;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.valid = i_cfg_valid;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    i2cdw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_cmd     (i_cmd),
        .i_payload (i_payload),
        .i_sda_in  (i_sda_in),
        .i_pop     (w_item_pop),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    i2cdw_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res_in)
    );

    i2cdw_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_res_out)
    );

    assign o_scl_out   = w_res_out.scl_out;
    assign o_sda_out   = w_res_out.sda_out;
    assign o_busy_res  = w_res_out.busy_res;
    assign o_accepted  = w_res_out.accepted;
    assign o_done_res  = w_res_out.done_res;
    assign o_ack_error = w_res_out.ack_error;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] payload;
        logic       sda;
    } t_bus_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_cmd = i2cdw_pkg::CMD_TICK;
    logic [7:0] i_payload = 8'h00;
    logic       i_sda_in = 1'b1;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_scl_out;
    logic       o_sda_out;
    logic       o_busy_res;
    logic       o_accepted;
    logic       o_done_res;
    logic       o_ack_error;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = i2cdw_pkg::CFG_SLAVE_ADDRESS;
    logic [7:0] i_cfg_data = 8'h00;

    i2c_display_write_master DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_payload   (i_payload),
        .i_sda_in    (i_sda_in),
        .empty       (empty),
        .pop         (pop),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_busy_res  (o_busy_res),
        .o_accepted  (o_accepted),
        .o_done_res  (o_done_res),
        .o_ack_error (o_ack_error),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // requests waiting to be offered, and line states still owed by the block
    t_bus_req           req_backlog[$];
    i2cdw_pkg::t_result line_states_due[$];

    // shadow copy of the bus engine
    logic [7:0]        cfg_addr = i2cdw_pkg::RST_SLAVE_ADDRESS;
    logic [7:0]        cfg_tmo = i2cdw_pkg::RST_ACK_TIMEOUT;
    logic [7:0]        cfg_tpu = i2cdw_pkg::RST_TICKS_PER_US;
    i2cdw_pkg::t_phase bus_phase = i2cdw_pkg::PH_IDLE;
    logic [1:0]        byte_sel = 2'd0;
    logic [2:0]        bit_num = 3'd0;
    logic [9:0]        wait_ticks = 10'd0;
    logic [7:0]        high_samples = 8'd0;
    logic [7:0]        tx_shift = 8'd0;
    logic [7:0]        tx_payload = 8'd0;
    logic              tx_is_data = 1'b0;
    logic              scl_drv = 1'b1;
    logic              sda_drv = 1'b1;
    logic              nack_seen = 1'b0;

    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned writes_done = 0;
    int unsigned nack_aborts = 0;
    int unsigned refused_reqs = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    logic        req_taken = 1'b0;

    task automatic enter_phase(input i2cdw_pkg::t_phase next, input logic [2:0] units);
        logic [7:0] u;
        int         prod;
        u = (cfg_tpu == 8'd0) ? 8'd1 : cfg_tpu;
        prod = int'(units) * int'(u);
        bus_phase = next;
        wait_ticks = prod[9:0];
    endtask

    task automatic send_bit();
        scl_drv = 1'b0;
        sda_drv = tx_shift[7];
        tx_shift = {tx_shift[6:0], 1'b0};
        enter_phase(i2cdw_pkg::PH_BIT_SETUP, i2cdw_pkg::UNITS_BIT);
    endtask

    task automatic send_byte(input logic [7:0] value);
        tx_shift = value;
        bit_num = 3'd0;
        send_bit();
    endtask

    task automatic send_stop();
        scl_drv = 1'b0;
        sda_drv = 1'b0;
        enter_phase(i2cdw_pkg::PH_STOP_A, i2cdw_pkg::UNITS_EDGE);
    endtask

    task automatic step_bus(input logic sda, output logic fin);
        logic [8:0] n;
        fin = 1'b0;
        if (bus_phase == i2cdw_pkg::PH_ACK_POLL) begin
            if (!sda) begin
                scl_drv = 1'b0;
                if (byte_sel >= 2'd2) begin
                    send_stop();
                end else begin
                    byte_sel = byte_sel + 2'd1;
                    if (byte_sel == 2'd1)
                        send_byte(tx_is_data ? i2cdw_pkg::CTRL_DATA
                                             : i2cdw_pkg::CTRL_COMMAND);
                    else
                        send_byte(tx_payload);
                end
            end else begin
                n = {1'b0, high_samples} + 9'd1;
                if (n > {1'b0, cfg_tmo}) begin
                    nack_seen = 1'b1;
                    send_stop();
                end else begin
                    high_samples = n[7:0];
                end
            end
        end else if (bus_phase != i2cdw_pkg::PH_IDLE) begin
            if (wait_ticks > 10'd1) begin
                wait_ticks = wait_ticks - 10'd1;
            end else begin
                wait_ticks = 10'd0;
                case (bus_phase)
                    i2cdw_pkg::PH_START_A: begin
                        sda_drv = 1'b0;
                        enter_phase(i2cdw_pkg::PH_START_B, i2cdw_pkg::UNITS_EDGE);
                    end
                    i2cdw_pkg::PH_START_B: begin
                        byte_sel = 2'd0;
                        send_byte(cfg_addr);
                    end
                    i2cdw_pkg::PH_BIT_SETUP: begin
                        scl_drv = 1'b1;
                        enter_phase(i2cdw_pkg::PH_BIT_HIGH, i2cdw_pkg::UNITS_BIT);
                    end
                    i2cdw_pkg::PH_BIT_HIGH: begin
                        scl_drv = 1'b0;
                        enter_phase(i2cdw_pkg::PH_BIT_LOW, i2cdw_pkg::UNITS_BIT);
                    end
                    i2cdw_pkg::PH_BIT_LOW: begin
                        if (bit_num >= 3'd7) begin
                            bit_num = 3'd0;
                            sda_drv = 1'b1;
                            enter_phase(i2cdw_pkg::PH_ACK_SETUP, i2cdw_pkg::UNITS_ACK);
                        end else begin
                            bit_num = bit_num + 3'd1;
                            send_bit();
                        end
                    end
                    i2cdw_pkg::PH_ACK_SETUP: begin
                        scl_drv = 1'b1;
                        enter_phase(i2cdw_pkg::PH_ACK_CLOCK, i2cdw_pkg::UNITS_ACK);
                    end
                    i2cdw_pkg::PH_ACK_CLOCK: begin
                        high_samples = 8'd0;
                        bus_phase = i2cdw_pkg::PH_ACK_POLL;
                    end
                    i2cdw_pkg::PH_STOP_A: begin
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        enter_phase(i2cdw_pkg::PH_STOP_B, i2cdw_pkg::UNITS_EDGE);
                    end
                    i2cdw_pkg::PH_STOP_B: begin
                        bus_phase = i2cdw_pkg::PH_IDLE;
                        fin = 1'b1;
                    end
                    default: begin
                        bus_phase = i2cdw_pkg::PH_IDLE;
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                    end
                endcase
            end
        end
    endtask

    task automatic predict_bus_tick(input logic [1:0] cmd, input logic [7:0] payload,
                                    input logic sda, output i2cdw_pkg::t_result r);
        logic fin;
        r = '0;
        if (bus_phase == i2cdw_pkg::PH_IDLE &&
            (cmd == i2cdw_pkg::CMD_COMMAND || cmd == i2cdw_pkg::CMD_DATA)) begin
            r.accepted = 1'b1;
            tx_payload = payload;
            tx_is_data = (cmd == i2cdw_pkg::CMD_DATA);
            nack_seen = 1'b0;
            byte_sel = 2'd0;
            bit_num = 3'd0;
            high_samples = 8'd0;
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            enter_phase(i2cdw_pkg::PH_START_A, i2cdw_pkg::UNITS_EDGE);
        end else begin
            step_bus(sda, fin);
            if (fin) begin
                r.done_res = 1'b1;
                r.ack_error = nack_seen;
            end
        end
        r.scl_out = scl_drv;
        r.sda_out = sda_drv;
        r.busy_res = (bus_phase != i2cdw_pkg::PH_IDLE);
    endtask

    function automatic string field_name(input int k);
        case (k)
            5: return "scl_out";
            4: return "sda_out";
            3: return "busy_res";
            2: return "accepted";
            1: return "done_res";
            default: return "ack_error";
        endcase
    endfunction

    // request side: offers the oldest backlog entry, holds it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && req_taken)
                void'(req_backlog.pop_front());
            if (!(push && !req_taken)) begin
                if (req_backlog.size() != 0 &&
                    ((items_taken >= 700 && items_taken < 1200) ||
                     $urandom_range(0, 99) >= 6)) begin
                    push <= 1'b1;
                    i_cmd <= req_backlog[0].cmd;
                    i_payload <= req_backlog[0].payload;
                    i_sda_in <= req_backlog[0].sda;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side: random pops, a run of steady pops and one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (holdoff_left != 0) begin
            pop <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else if (!holdoff_done && results_seen >= 150) begin
            holdoff_done = 1'b1;
            holdoff_left = 150;
            pop <= 1'b0;
        end else if (results_seen >= 800 && results_seen < 1300) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge i_clk) begin : result_check
        i2cdw_pkg::t_result pred;
        i2cdw_pkg::t_result want;
        logic [5:0]         wv;
        logic [5:0]         gv;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                req_taken = 1'b1;
                predict_bus_tick(i_cmd, i_payload, i_sda_in, pred);
                if ((i_cmd == i2cdw_pkg::CMD_COMMAND || i_cmd == i2cdw_pkg::CMD_DATA) &&
                    !pred.accepted)
                    refused_reqs++;
                line_states_due.push_back(pred);
                items_taken++;
            end
            if (pop && !empty) begin
                gv = {o_scl_out, o_sda_out, o_busy_res, o_accepted, o_done_res, o_ack_error};
                if (line_states_due.size() == 0) begin
                    $display("%0t: result with nothing expected, got %b", $time, gv);
                    fail_count++;
                end else begin
                    want = line_states_due.pop_front();
                    wv = want;
                    for (int k = 5; k >= 0; k--) begin
                        if (gv[k] !== wv[k]) begin
                            $display("%0t: %s expected %0b got %0b", $time, field_name(k),
                                     wv[k], gv[k]);
                            fail_count++;
                        end
                    end
                end
                if (o_done_res)
                    writes_done++;
                if (o_ack_error)
                    nack_aborts++;
                results_seen++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic queue_item(input logic [1:0] cmd, input logic [7:0] payload,
                              input logic sda);
        t_bus_req r;
        r.cmd = cmd;
        r.payload = payload;
        r.sda = sda;
        req_backlog.push_back(r);
    endtask

    task automatic add_random(input int count, input int req_pct, input int sda_hi_pct);
        int         roll;
        logic [1:0] cmd;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < req_pct)
                cmd = $urandom_range(0, 1) ? i2cdw_pkg::CMD_DATA : i2cdw_pkg::CMD_COMMAND;
            else if (roll < req_pct + 2)
                cmd = CMD_SPARE;
            else
                cmd = i2cdw_pkg::CMD_TICK;
            queue_item(cmd, 8'($urandom_range(0, 255)), $urandom_range(0, 99) < sda_hi_pct);
        end
    endtask

    // let everything drain, then keep ticking with acks until the bus is idle
    task automatic drain_bus();
        do begin
            while (req_backlog.size() != 0 || line_states_due.size() != 0)
                @(posedge i_clk);
            if (bus_phase != i2cdw_pkg::PH_IDLE) begin
                for (int k = 0; k < 64; k++)
                    queue_item(i2cdw_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
            end
        end while (req_backlog.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            i2cdw_pkg::CFG_SLAVE_ADDRESS: cfg_addr = val;
            i2cdw_pkg::CFG_ACK_TIMEOUT:   cfg_tmo = val;
            i2cdw_pkg::CFG_TICKS_PER_US:  cfg_tpu = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] addr, input logic [7:0] tmo,
                                input logic [7:0] tpu);
        write_reg(i2cdw_pkg::CFG_SLAVE_ADDRESS, addr);
        write_reg(i2cdw_pkg::CFG_ACK_TIMEOUT, tmo);
        write_reg(i2cdw_pkg::CFG_TICKS_PER_US, tpu);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks, the spare code, then a command request and refusals while busy
        queue_item(i2cdw_pkg::CMD_TICK, 8'h00, 1'b0);
        queue_item(CMD_SPARE, 8'hFF, 1'b1);
        queue_item(i2cdw_pkg::CMD_TICK, 8'hFF, 1'b1);
        queue_item(i2cdw_pkg::CMD_COMMAND, 8'hFF, 1'b0);
        queue_item(i2cdw_pkg::CMD_DATA, 8'h00, 1'b1);
        queue_item(CMD_SPARE, 8'h55, 1'b0);
        queue_item(i2cdw_pkg::CMD_COMMAND, 8'hAA, 1'b1);
        for (int k = 0; k < 12; k++)
            queue_item(i2cdw_pkg::CMD_TICK, 8'h00, k[0]);
        add_random(400, 2, 20);
        drain_bus();

        // single-sample timeout with extreme addresses
        program_regs(8'h00, 8'd1, 8'd1);
        queue_item(i2cdw_pkg::CMD_DATA, 8'h00, 1'b0);
        add_random(300, 3, 50);
        drain_bus();

        program_regs(8'hFF, 8'd255, 8'd2);
        add_random(300, 2, 30);
        drain_bus();

        // zero timeout and zero ticks per unit
        program_regs(8'h3C, 8'd0, 8'd0);
        add_random(200, 3, 40);
        drain_bus();

        // a request on every tick, so one lands on each done tick
        program_regs(8'($urandom_range(0, 255)), 8'd3, 8'd1);
        add_random(400, 100, 25);
        drain_bus();

        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)), 8'd3);
        add_random(300, 3, 35);
        drain_bus();

        // slowest timing, one transfer run to completion
        program_regs(i2cdw_pkg::RST_SLAVE_ADDRESS, 8'd255, 8'd255);
        queue_item(i2cdw_pkg::CMD_COMMAND, 8'($urandom_range(0, 255)), 1'b0);
        add_random(50, 10, 20);
        drain_bus();

        repeat (8) @(posedge i_clk);
        $display("%0d bus ticks checked, %0d byte writes finished, %0d ended on a missing ack",
                 results_seen, writes_done, nack_aborts);
        $display("%0d requests refused while busy, timing from zero to 255 ticks per unit",
                 refused_reqs);
        if (fail_count == 0 && line_states_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: i2c_display_write_master.f
+incdir+hdl
hdl/i2cdw_pkg.sv
hdl/i2cdw_front.sv
hdl/i2cdw_result_q.sv
hdl/i2cdw_engine.sv
hdl/i2c_display_write_master.sv
sim/testbench.sv
